// ===== rtl/csc_pkg.sv =====
`timescale 1ns / 1ps

package csc_pkg;

	// fraction bits of the fixed-point coefficients
	localparam int COEF_FRAC_BITS_DEF = 16;
	localparam int COEF_FRAC_BITS_MIN = 10;
	localparam int COEF_FRAC_BITS_MAX = 24;

	// component width and chroma offset
	localparam int COMP_W      = 8;
	localparam int CHROMA_OFS  = 128;
	localparam int COMP_MAX    = 255;

	// direction register codes
	typedef enum logic {
		DIR_RGB2YCC = 1'b0,
		DIR_YCC2RGB = 1'b1
	} dir_t;

	// matrices in units of 1e-4, row = output component, column = input component
	typedef int coef_mat_t [3][3];

	localparam coef_mat_t FWD_E4 = '{
		'{ 2990,  5870,  1140},
		'{-1687, -3313,  5000},
		'{ 5000, -4187,  -813}
	};

	localparam coef_mat_t INV_E4 = '{
		'{10000,     0, 14020},
		'{10000, -3441, -7141},
		'{10000, 17720,     0}
	};

	// c * 1e-4 * 2^frac, rounded to nearest, halves away from zero
	function automatic longint scale_coef(input int c_e4, input int frac);
		longint mag;
		longint q;
		mag = (c_e4 < 0) ? -longint'(c_e4) : longint'(c_e4);
		q   = ((mag << frac) * 2 + 10000) / 20000;
		return (c_e4 < 0) ? -q : q;
	endfunction

endpackage

// ===== rtl/color_space_converter_top.sv =====
`timescale 1ns / 1ps

// Full-range BT.601 RGB <-> YCbCr converter. One pixel (three 8-bit components) per beat;
// a new pixel can be taken every clock while the output is not stalled. The four stages are:
// input register with chroma offset, the nine coefficient multiplies, the three-term sums, and
// rounding / offset / clamp into the output register. Any empty stage absorbs a beat while
// the output is stalled. cfg_data bit 0 selects the direction (0: RGB to YCbCr, 1: YCbCr to
// RGB); cfg_ready is always high, and the direction should only be changed while no pixel is
// in flight.
module color_space_converter_top #(
	parameter int COEF_FRAC_BITS = csc_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,

	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic                        cfg_data,

	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [csc_pkg::COMP_W-1:0]  comp_a,
	input  logic [csc_pkg::COMP_W-1:0]  comp_b,
	input  logic [csc_pkg::COMP_W-1:0]  comp_c,

	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [csc_pkg::COMP_W-1:0]  out_a,
	output logic [csc_pkg::COMP_W-1:0]  out_b,
	output logic [csc_pkg::COMP_W-1:0]  out_c
);

	import csc_pkg::*;

	localparam int XW = COMP_W + 1;              // signed operand
	localparam int CW = COEF_FRAC_BITS + 2;      // signed coefficient, |k| < 2
	localparam int PW = CW + XW;                 // product
	localparam int SW = PW + 2;                  // sum of three products
	localparam int RW = SW - COEF_FRAC_BITS;     // rounded integer
	localparam logic signed [SW-1:0] HALF = SW'(longint'(1) << (COEF_FRAC_BITS - 1));

	dir_t direction_q;

	logic adv1, adv2, adv3, adv4;
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	dir_t mode_s1, mode_s2, mode_s3;

	logic signed [XW-1:0] x_s1   [3];
	logic signed [PW-1:0] prod_s2 [3][3];
	logic signed [SW-1:0] sum_s3 [3];
	logic [COMP_W-1:0]    res_s4 [3];

	logic signed [XW-1:0] x_in   [3];
	logic signed [PW-1:0] prod_d [3][3];
	logic signed [SW-1:0] sum_d  [3];
	logic [COMP_W-1:0]    res_d  [3];

	// config
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= DIR_RGB2YCC;
		end else if (cfg_valid && cfg_ready) begin
			direction_q <= dir_t'(cfg_data);
		end
	end

	// stage advance: a stage moves when the next one moves or is empty
	assign adv4     = !out_stall || !valid_s4;
	assign adv3     = adv4 || !valid_s3;
	assign adv2     = adv3 || !valid_s2;
	assign adv1     = adv2 || !valid_s1;
	assign in_stall = !adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (adv1) valid_s1 <= in_valid;
			if (adv2) valid_s2 <= valid_s1;
			if (adv3) valid_s3 <= valid_s2;
			if (adv4) valid_s4 <= valid_s3;
		end
	end

	// stage 1: operands, chroma offset removed in the inverse direction
	always_comb begin
		x_in[0] = signed'({1'b0, comp_a});
		x_in[1] = signed'({1'b0, comp_b});
		x_in[2] = signed'({1'b0, comp_c});
		if (direction_q == DIR_YCC2RGB) begin
			x_in[1] = x_in[1] - XW'(CHROMA_OFS);
			x_in[2] = x_in[2] - XW'(CHROMA_OFS);
		end
	end

	// stage 2: nine products against the selected matrix (zero terms fold away)
	always_comb begin
		logic signed [CW-1:0] k;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				if (mode_s1 == DIR_YCC2RGB) begin
					k = CW'(scale_coef(INV_E4[i][j], COEF_FRAC_BITS));
				end else begin
					k = CW'(scale_coef(FWD_E4[i][j], COEF_FRAC_BITS));
				end
				prod_d[i][j] = PW'(k) * PW'(x_s1[j]);
			end
		end
	end

	// stage 3: row sums
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sum_d[i] = SW'(prod_s2[i][0]) + SW'(prod_s2[i][1]) + SW'(prod_s2[i][2]);
		end
	end

	// stage 4: round half away from zero, chroma offset, clamp
	// negative sums take half-1 so the arithmetic shift rounds the magnitude up at ties
	always_comb begin
		logic signed [SW-1:0] rnd;
		logic signed [RW-1:0] r;
		for (int i = 0; i < 3; i++) begin
			rnd = sum_s3[i] + (sum_s3[i][SW-1] ? (HALF - SW'(1)) : HALF);
			r   = RW'(rnd >>> COEF_FRAC_BITS);
			if (mode_s3 == DIR_RGB2YCC && i > 0) begin
				r = r + RW'(CHROMA_OFS);
			end
			if (r < 0) begin
				res_d[i] = '0;
			end else if (r > RW'(COMP_MAX)) begin
				res_d[i] = COMP_W'(COMP_MAX);
			end else begin
				res_d[i] = r[COMP_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			x_s1    <= x_in;
			mode_s1 <= direction_q;
		end
		if (adv2 && valid_s1) begin
			prod_s2 <= prod_d;
			mode_s2 <= mode_s1;
		end
		if (adv3 && valid_s2) begin
			sum_s3  <= sum_d;
			mode_s3 <= mode_s2;
		end
		if (adv4 && valid_s3) begin
			res_s4  <= res_d;
		end
	end

	assign out_valid = valid_s4;
	assign out_a     = res_s4[0];
	assign out_b     = res_s4[1];
	assign out_c     = res_s4[2];

	// an empty output stage never holds back the input
	a_no_stall_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output stage");

	// an accepted beat lands in stage 1
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> valid_s1)
		else $error("accepted beat lost at stage 1");

	// a blocked stage keeps its beat
	a_s2_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !adv2) |=> valid_s2)
		else $error("stage 2 beat dropped while blocked");

	a_s3_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && !adv3) |=> (valid_s3 && $stable(sum_s3[0])))
		else $error("stage 3 beat changed while blocked");

endmodule

// ===== tb/sv/tb_color_space_converter_top.sv =====
`timescale 1ns / 1ps

module tb_color_space_converter_top;
	import csc_pkg::*;

	localparam int FRAC        = COEF_FRAC_BITS_DEF;
	localparam int HOLD_CYCLES = 200;
	localparam int STALL_LIMIT = 3000;
	localparam int PHASE_ITEMS = 250;

	typedef logic [COMP_W-1:0] comp_t;

	typedef struct packed {
		comp_t a;
		comp_t b;
		comp_t c;
	} pixel_t;

	class conversion_checker;
		dir_t   direction;
		pixel_t pending_pixels[$];
		int     errors;

		function new();
			direction = DIR_RGB2YCC;
			errors    = 0;
		endfunction

		// coefficient in 1e-4 units to fixed point, nearest with halves away from zero
		function longint to_fixed(int c_e4);
			longint mag;
			longint q;
			mag = (c_e4 < 0) ? -longint'(c_e4) : longint'(c_e4);
			q   = (mag * (longint'(1) << FRAC) + 5000) / 10000;
			return (c_e4 < 0) ? -q : q;
		endfunction

		function comp_t saturate(longint v);
			if (v < 0)
				return '0;
			if (v > COMP_MAX)
				return comp_t'(COMP_MAX);
			return comp_t'(v);
		endfunction

		function pixel_t convert_pixel(comp_t a, comp_t b, comp_t c);
			longint    x[3];
			longint    sum;
			longint    mag;
			longint    v;
			coef_mat_t m;
			comp_t     res[3];
			pixel_t    p;
			x[0] = a;
			x[1] = b;
			x[2] = c;
			if (direction == DIR_YCC2RGB) begin
				x[1] -= CHROMA_OFS;
				x[2] -= CHROMA_OFS;
				m = INV_E4;
			end else begin
				m = FWD_E4;
			end
			for (int i = 0; i < 3; i++) begin
				sum = 0;
				for (int j = 0; j < 3; j++)
					sum += to_fixed(m[i][j]) * x[j];
				mag = (sum < 0) ? -sum : sum;
				v   = (mag + (longint'(1) << (FRAC - 1))) >>> FRAC;
				if (sum < 0)
					v = -v;
				if (direction == DIR_RGB2YCC && i > 0)
					v += CHROMA_OFS;
				res[i] = saturate(v);
			end
			p.a = res[0];
			p.b = res[1];
			p.c = res[2];
			return p;
		endfunction

		function void note_pixel(comp_t a, comp_t b, comp_t c);
			pending_pixels.push_back(convert_pixel(a, b, c));
		endfunction

		function void check_pixel(comp_t a, comp_t b, comp_t c);
			pixel_t exp_p;
			if (pending_pixels.size() == 0) begin
				$error("unexpected pixel %0d %0d %0d", a, b, c);
				errors++;
				return;
			end
			exp_p = pending_pixels.pop_front();
			if (a !== exp_p.a) begin
				$error("out_a: expected %0d, got %0d", exp_p.a, a);
				errors++;
			end
			if (b !== exp_p.b) begin
				$error("out_b: expected %0d, got %0d", exp_p.b, b);
				errors++;
			end
			if (c !== exp_p.c) begin
				$error("out_c: expected %0d, got %0d", exp_p.c, c);
				errors++;
			end
		endfunction

		function int pending();
			return pending_pixels.size();
		endfunction
	endclass

	logic  clk       = 1'b0;
	logic  arst_n    = 1'b0;
	logic  cfg_valid = 1'b0;
	logic  cfg_ready;
	logic  cfg_data  = 1'b0;
	logic  in_valid  = 1'b0;
	logic  in_stall;
	comp_t comp_a    = '0;
	comp_t comp_b    = '0;
	comp_t comp_c    = '0;
	logic  out_valid;
	logic  out_stall = 1'b0;
	comp_t out_a;
	comp_t out_b;
	comp_t out_c;

	conversion_checker sb;
	int   idle_pct   = 0;
	int   stall_pct  = 0;
	logic hold_arm   = 1'b0;
	int   hold_left  = 0;
	int   quiet_cycles = 0;

	color_space_converter_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.comp_a    (comp_a),
		.comp_b    (comp_b),
		.comp_c    (comp_c),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_a     (out_a),
		.out_b     (out_b),
		.out_c     (out_c)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// output side: check the beat, then pick the stall for the next edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				sb.check_pixel(out_a, out_b, out_c);
			if (hold_left != 0) begin
				hold_left = hold_left - 1;
				out_stall <= 1'b1;
			end else if (hold_arm) begin
				hold_arm  = 1'b0;
				hold_left = HOLD_CYCLES;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	task automatic write_direction(input dir_t d);
		cfg_valid <= 1'b1;
		cfg_data  <= d;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.direction = d;
		cfg_valid <= 1'b0;
	endtask

	task automatic send_pixel(input comp_t a, input comp_t b, input comp_t c);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		comp_a   <= a;
		comp_b   <= b;
		comp_c   <= c;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_pixel(a, b, c);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic comp_t pick_comp();
		case ($urandom_range(7))
			0: return '0;
			1: return comp_t'(COMP_MAX);
			2: return comp_t'(CHROMA_OFS);
			default: return comp_t'($urandom_range(COMP_MAX));
		endcase
	endfunction

	initial begin
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// forward: black, white, primaries, secondaries; blue drives Cb into saturation
		write_direction(DIR_RGB2YCC);
		send_pixel(8'd0,   8'd0,   8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd0,   8'd0);
		send_pixel(8'd0,   8'd255, 8'd0);
		send_pixel(8'd0,   8'd0,   8'd255);
		send_pixel(8'd255, 8'd255, 8'd0);
		send_pixel(8'd0,   8'd255, 8'd255);
		send_pixel(8'd255, 8'd0,   8'd255);
		send_pixel(8'd128, 8'd128, 8'd128);
		send_pixel(8'd170, 8'd85,  8'd42);
		drain();

		// inverse: neutral grays, chroma extremes, both-rail saturation
		write_direction(DIR_YCC2RGB);
		send_pixel(8'd0,   8'd128, 8'd128);
		send_pixel(8'd255, 8'd128, 8'd128);
		send_pixel(8'd0,   8'd0,   8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd0,   8'd255);
		send_pixel(8'd0,   8'd255, 8'd0);
		send_pixel(8'd128, 8'd0,   8'd255);
		send_pixel(8'd128, 8'd255, 8'd0);
		send_pixel(8'd76,  8'd85,  8'd255);
		send_pixel(8'd29,  8'd255, 8'd107);
		send_pixel(8'd150, 8'd44,  8'd21);
		send_pixel(8'd1,   8'd127, 8'd129);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph >> 1)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 62; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 62; end
				default: begin idle_pct = 13; stall_pct = 13; end
			endcase
			write_direction(ph[0] ? DIR_YCC2RGB : DIR_RGB2YCC);
			// long output hold while input keeps streaming, to back the pipe up
			if (ph == 0)
				hold_arm = 1'b1;
			repeat (PHASE_ITEMS)
				send_pixel(pick_comp(), pick_comp(), pick_comp());
			drain();
		end

		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/csc_pkg.sv
rtl/color_space_converter_top.sv
tb/sv/tb_color_space_converter_top.sv
